>>> hw/rtl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, codes and constants for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W      = 32;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 5;
  localparam int IN_TDATA_W = KEY_W + VAL_W;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;   // -1

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

endpackage

>>> hw/rtl/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_top
// Fully associative key-value store with LRU replacement, get/put requests.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; gets and puts may follow back to back. A get
//   stalls in the input register while the result register holds an unaccepted result.
// A get passes the input register and then the result register, with one parallel
//   key compare plus rank update between the two.
// Reset: clears valid bits, ranks, occupancy and handshake; capacity = 16.
module lru_key_value_cache_top #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]        cfg_wr_data,   // capacity
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lkvc_pkg::IN_TDATA_W-1:0]   in_tdata,      // key[31:0], value[63:32]
  input  logic                              in_tuser,      // op
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lkvc_pkg::VAL_W-1:0]        out_tdata,     // read_value
  output logic                              out_tuser      // hit
);
  import lkvc_pkg::*;

  localparam int RW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OW = $clog2(DEPTH + 1);
  localparam int CW = (OW > CAP_W) ? OW : CAP_W;

  // configuration
  logic [CAP_W-1:0] cap_r;
  logic [CW-1:0]    cap_x;
  logic [CW-1:0]    cap_eff;

  // input stage
  logic  s_vld_r;
  logic  s_op_r;
  key_t  s_key_r;
  val_t  s_val_r;
  logic  s_go;

  // result stage
  logic  out_vld_r;
  logic  out_hit_r;
  val_t  out_data_r;

  // store
  key_t           key_r   [DEPTH];
  val_t           value_r [DEPTH];
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [RW-1:0]  rank_r  [DEPTH];
  logic [RW-1:0]  rank_nxt[DEPTH];
  logic [OW-1:0]  occ_r, occ_nxt;

  // lookup
  logic [DEPTH-1:0] hit_vec;
  logic             hit_any;
  logic [RW-1:0]    hit_rank;
  val_t             hit_val;
  logic             need_evict;
  logic [RW-1:0]    oldest_rank;
  logic [DEPTH-1:0] victim_vec, victim_oh;
  logic [DEPTH-1:0] valid_aft, free_vec, free_oh;
  logic [DEPTH-1:0] key_we, val_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_comb begin
    cap_x = CW'(cap_r);
    if (cap_x == '0) begin
      cap_eff = CW'(1);
    end else if (cap_x > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = cap_x;
    end
  end

  // a put never blocks on the result side
  assign s_go      = s_vld_r && (s_op_r == OP_PUT || !out_vld_r || out_tready);
  assign in_tready = !s_vld_r || s_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_tready) begin
      s_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s_op_r  <= in_tuser;
      s_key_r <= in_tdata[KEY_W-1:0];
      s_val_r <= in_tdata[IN_TDATA_W-1:KEY_W];
    end
  end

  // parallel compare and selects
  always_comb begin
    hit_rank = '0;
    hit_val  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit_vec[i]    = valid_r[i] && (key_r[i] == s_key_r);
      victim_vec[i] = valid_r[i] && (rank_r[i] == oldest_rank);
      if (hit_vec[i]) begin
        hit_rank = hit_rank | rank_r[i];
        hit_val  = hit_val | value_r[i];
      end
    end
  end

  assign hit_any     = |hit_vec;
  // ranks of valid slots are a permutation of 0..occ-1, so the oldest is occ-1
  assign oldest_rank = RW'(occ_r - 1'b1);
  assign need_evict  = (s_op_r == OP_PUT) && !hit_any && (CW'(occ_r) >= cap_eff);
  assign victim_oh   = victim_vec & (~victim_vec + 1'b1);
  assign valid_aft   = valid_r & ~(need_evict ? victim_oh : '0);
  assign free_vec    = ~valid_aft;
  assign free_oh     = free_vec & (~free_vec + 1'b1);

  always_comb begin
    valid_nxt = valid_r;
    occ_nxt   = occ_r;
    key_we    = '0;
    val_we    = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (hit_any) begin
      // touch: slots more recent than the hit age by one
      for (int i = 0; i < DEPTH; i++) begin
        if (hit_vec[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_r[i] && rank_r[i] < hit_rank) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      if (s_op_r == OP_PUT) begin
        val_we = hit_vec;
      end
    end else if (s_op_r == OP_PUT) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (free_oh[i]) begin
          rank_nxt[i] = '0;
        end else if (valid_aft[i]) begin
          rank_nxt[i] = rank_r[i] + 1'b1;
        end
      end
      valid_nxt = valid_aft | free_oh;
      key_we    = free_oh;
      val_we    = free_oh;
      occ_nxt   = need_evict ? occ_r : occ_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      occ_r   <= '0;
      for (int i = 0; i < DEPTH; i++) begin
        rank_r[i] <= '0;
      end
    end else if (s_go) begin
      valid_r <= valid_nxt;
      occ_r   <= occ_nxt;
      for (int i = 0; i < DEPTH; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (s_go && key_we[i]) begin
        key_r[i] <= s_key_r;
      end
      if (s_go && val_we[i]) begin
        value_r[i] <= s_val_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s_go && s_op_r == OP_GET) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go && s_op_r == OP_GET) begin
      out_hit_r  <= hit_any;
      out_data_r <= hit_any ? hit_val : MISS_VALUE;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_data_r;

endmodule
